[hw/rtl/hstwm_pkg.sv]
`timescale 1ns / 1ps

package hstwm_pkg;

  localparam int PHASE_W = 5;

  // sequencer phases
  localparam logic [PHASE_W-1:0] PH_IDLE    = 5'd0;
  localparam logic [PHASE_W-1:0] PH_ST0     = 5'd1;
  localparam logic [PHASE_W-1:0] PH_ST1     = 5'd2;
  localparam logic [PHASE_W-1:0] PH_ST2     = 5'd3;
  localparam logic [PHASE_W-1:0] PH_ST3     = 5'd4;
  localparam logic [PHASE_W-1:0] PH_ST4     = 5'd5;
  localparam logic [PHASE_W-1:0] PH_ST5     = 5'd6;
  localparam logic [PHASE_W-1:0] PH_ST6     = 5'd7;
  localparam logic [PHASE_W-1:0] PH_TX_HI   = 5'd8;
  localparam logic [PHASE_W-1:0] PH_TX_LO   = 5'd9;
  localparam logic [PHASE_W-1:0] PH_ACK_HI  = 5'd10;
  localparam logic [PHASE_W-1:0] PH_ACK_LO  = 5'd11;
  localparam logic [PHASE_W-1:0] PH_WAIT    = 5'd12;
  localparam logic [PHASE_W-1:0] PH_RX_HI   = 5'd13;
  localparam logic [PHASE_W-1:0] PH_RX_LO   = 5'd14;
  localparam logic [PHASE_W-1:0] PH_MACK_HI = 5'd15;
  localparam logic [PHASE_W-1:0] PH_MACK_LO = 5'd16;
  localparam logic [PHASE_W-1:0] PH_TERM_HI = 5'd17;
  localparam logic [PHASE_W-1:0] PH_TERM_LO = 5'd18;

  localparam logic [4:0] STATUS_CMD = 5'd7;
  localparam logic [7:0] CRC_POLY   = 8'h8C;

  // configuration register indexes
  localparam logic REG_HALF_PERIOD   = 1'b0;
  localparam logic REG_READY_TIMEOUT = 1'b1;

  localparam logic [15:0] HALF_PERIOD_RESET   = 16'd1000;
  localparam logic [23:0] READY_TIMEOUT_RESET = 24'd0;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;

  // reflected CRC-8 over a bit-reversed byte
  function automatic logic [7:0] crc_update(input logic [7:0] crc_in, input logic [7:0] d);
    logic [7:0] crc;
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = d[i];
    end
    crc = crc_in ^ r;
    for (int i = 0; i < 8; i++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

[hw/rtl/humidity_sensor_two_wire_master_top.sv]
`timescale 1ns / 1ps
// Two-wire master for a humidity/temperature sensor, stepped by timing ticks.
// Input stream (s_axis): one word per tick with a start request, a 5-bit
// command and the sampled DATA pin level. Output stream (m_axis): one word per
// accepted tick with the pin levels (sck, data_out, data_enable), busy/done,
// the no-ack and timeout flags, the value read, received and computed CRC and
// a CRC match flag. Command 7 reads the status byte; any other command waits
// for DATA low, then reads two bytes. Both read a CRC byte and end; a no-ack
// or timeout ends it early. Configuration: cfg_we/cfg_addr/cfg_wdata, index 0
// = half period in ticks, index 1 = ready timeout in ticks (0 waits forever).
// Write only while idle. A tick's result word goes to the output register, or
// the skid register on a stall. Throughput: one tick per cycle unless stalled;
// the whole sequencer step is one pass of logic from tick to output register.
// Stall: a two-entry output buffer (output register plus skid register) keeps
// accepting while one result waits; s_axis_tready drops only when both are
// full, and no word is lost or repeated.
// Reset (rst, synchronous): sequencer idle, SCK high, DATA low and driven,
// config back to 1000 / 0, output buffer empty.
module humidity_sensor_two_wire_master_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] start_req, [5:1] command, [6] data_in, [7] zero
  input  logic [hstwm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] sck, [1] data_out, [2] data_enable, [3] busy_res, [4] done_res,
  // [5] no_ack, [6] timed_out, [22:7] value, [30:23] crc_received,
  // [38:31] crc_computed, [39] crc_match
  output logic [hstwm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [23:0] cfg_wdata
);
  import hstwm_pkg::*;

  // configuration
  logic [15:0] half_period_ticks;
  logic [23:0] ready_timeout_ticks;

  // sequencer state
  logic [PHASE_W-1:0] phase, phase_next;
  logic [2:0]  bit_count, bit_count_next;
  logic [15:0] delay_count, delay_count_next;
  logic [23:0] wait_count, wait_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [4:0]  command_latch, command_latch_next;
  logic [15:0] value_reg, value_reg_next;
  logic [7:0]  crc_running, crc_running_next;
  logic [7:0]  crc_read, crc_read_next;
  logic        pin_sck, pin_sck_next;
  logic        pin_data, pin_data_next;
  logic        pin_en, pin_en_next;
  logic [1:0]  byte_index, byte_index_next;
  logic        flag_noack, flag_noack_next;
  logic        flag_timeout, flag_timeout_next;
  logic        flag_crcgot, flag_crcgot_next;
  logic        done_pulse;

  // output buffer
  logic [OUT_TDATA_W-1:0] out_word, skid_word, result_word;
  logic out_valid, skid_valid;

  logic        accept;
  logic        start_req, data_in;
  logic [4:0]  command;
  logic [15:0] hp;
  logic        two_bytes;
  logic [1:0]  data_bytes;
  logic        crc_match;

  assign start_req = s_axis_tdata[0];
  assign command   = s_axis_tdata[5:1];
  assign data_in   = s_axis_tdata[6];

  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_word;

  // a zero half period counts as one tick
  assign hp         = (half_period_ticks == 16'd0) ? 16'd1 : half_period_ticks;
  assign two_bytes  = (command_latch != STATUS_CMD);
  assign data_bytes = two_bytes ? 2'd2 : 2'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks   <= HALF_PERIOD_RESET;
      ready_timeout_ticks <= READY_TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_HALF_PERIOD:   half_period_ticks   <= cfg_wdata[15:0];
        REG_READY_TIMEOUT: ready_timeout_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // one tick of the pin sequencer
  always_comb begin
    phase_next         = phase;
    bit_count_next     = bit_count;
    delay_count_next   = delay_count;
    wait_count_next    = wait_count;
    shift_byte_next    = shift_byte;
    command_latch_next = command_latch;
    value_reg_next     = value_reg;
    crc_running_next   = crc_running;
    crc_read_next      = crc_read;
    pin_sck_next       = pin_sck;
    pin_data_next      = pin_data;
    pin_en_next        = pin_en;
    byte_index_next    = byte_index;
    flag_noack_next    = flag_noack;
    flag_timeout_next  = flag_timeout;
    flag_crcgot_next   = flag_crcgot;
    done_pulse         = 1'b0;

    if (phase == PH_IDLE) begin
      if (start_req) begin
        command_latch_next = command;
        value_reg_next     = 16'd0;
        crc_read_next      = 8'd0;
        crc_running_next   = 8'd0;
        flag_noack_next    = 1'b0;
        flag_timeout_next  = 1'b0;
        flag_crcgot_next   = 1'b0;
        byte_index_next    = 2'd0;
        pin_data_next      = 1'b1;
        pin_en_next        = 1'b1;
        delay_count_next   = 16'd0;
        phase_next         = PH_ST0;
      end
    end else if (phase == PH_WAIT) begin
      // ready wait samples every tick, no half-period delay
      if (!data_in) begin
        delay_count_next = 16'd0;
        pin_en_next      = 1'b0;
        bit_count_next   = 3'd7;
        shift_byte_next  = 8'd0;
        phase_next       = PH_RX_HI;
      end else begin
        wait_count_next = wait_count + 24'd1;
        if (ready_timeout_ticks != 24'd0 && wait_count_next >= ready_timeout_ticks) begin
          flag_timeout_next = 1'b1;
          pin_en_next       = 1'b1;
          phase_next        = PH_IDLE;
          done_pulse        = 1'b1;
        end
      end
    end else if ({1'b0, delay_count} + 17'd1 < {1'b0, hp}) begin
      delay_count_next = delay_count + 16'd1;
    end else begin
      delay_count_next = 16'd0;
      unique case (phase)
        PH_ST0: begin pin_sck_next  = 1'b1; phase_next = PH_ST1; end
        PH_ST1: begin pin_data_next = 1'b0; phase_next = PH_ST2; end
        PH_ST2: begin pin_sck_next  = 1'b0; phase_next = PH_ST3; end
        PH_ST3: begin pin_sck_next  = 1'b1; phase_next = PH_ST4; end
        PH_ST4: begin pin_data_next = 1'b1; phase_next = PH_ST5; end
        PH_ST5: begin pin_sck_next  = 1'b0; phase_next = PH_ST6; end
        PH_ST6: begin
          shift_byte_next = {3'b000, command_latch};
          bit_count_next  = 3'd7;
          pin_data_next   = shift_byte_next[7];
          phase_next      = PH_TX_HI;
        end
        PH_TX_HI: begin pin_sck_next = 1'b1; phase_next = PH_TX_LO; end
        PH_TX_LO: begin
          pin_sck_next = 1'b0;
          if (bit_count == 3'd0) begin
            phase_next = PH_ACK_HI;
          end else begin
            bit_count_next = bit_count - 3'd1;
            pin_data_next  = shift_byte[bit_count_next];
            phase_next     = PH_TX_HI;
          end
        end
        PH_ACK_HI: begin
          pin_sck_next     = 1'b1;
          pin_en_next      = 1'b0;
          flag_noack_next  = data_in;
          crc_running_next = crc_update(8'd0, {3'b000, command_latch});
          phase_next       = PH_ACK_LO;
        end
        PH_ACK_LO: begin
          pin_sck_next    = 1'b0;
          pin_en_next     = 1'b1;
          byte_index_next = 2'd0;
          if (flag_noack) begin
            phase_next = PH_IDLE;
            done_pulse = 1'b1;
          end else if (!two_bytes) begin
            pin_en_next     = 1'b0;
            bit_count_next  = 3'd7;
            shift_byte_next = 8'd0;
            phase_next      = PH_RX_HI;
          end else begin
            pin_en_next     = 1'b0;
            wait_count_next = 24'd0;
            phase_next      = PH_WAIT;
          end
        end
        PH_RX_HI: begin
          pin_sck_next    = 1'b1;
          shift_byte_next = shift_byte | ({7'd0, data_in} << bit_count);
          phase_next      = PH_RX_LO;
        end
        PH_RX_LO: begin
          pin_sck_next = 1'b0;
          if (bit_count != 3'd0) begin
            bit_count_next = bit_count - 3'd1;
            phase_next     = PH_RX_HI;
          end else begin
            pin_en_next = 1'b1;
            if (byte_index < data_bytes) begin
              crc_running_next = crc_update(crc_running, shift_byte);
              if (two_bytes && byte_index == 2'd0) begin
                value_reg_next = {shift_byte, 8'd0};
              end else begin
                value_reg_next = value_reg | {8'd0, shift_byte};
              end
              byte_index_next = byte_index + 2'd1;
              pin_data_next   = 1'b0;
              phase_next      = PH_MACK_HI;
            end else begin
              crc_read_next    = shift_byte;
              flag_crcgot_next = 1'b1;
              pin_data_next    = 1'b1;
              phase_next       = PH_TERM_HI;
            end
          end
        end
        PH_MACK_HI: begin pin_sck_next = 1'b1; phase_next = PH_MACK_LO; end
        PH_MACK_LO: begin
          pin_sck_next    = 1'b0;
          pin_en_next     = 1'b0;
          bit_count_next  = 3'd7;
          shift_byte_next = 8'd0;
          phase_next      = PH_RX_HI;
        end
        PH_TERM_HI: begin pin_sck_next = 1'b1; phase_next = PH_TERM_LO; end
        PH_TERM_LO: begin
          pin_sck_next = 1'b0;
          phase_next   = PH_IDLE;
          done_pulse   = 1'b1;
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  assign crc_match = flag_crcgot_next && (crc_read_next == crc_running_next);

  assign result_word = {crc_match, crc_running_next, crc_read_next, value_reg_next,
                        flag_timeout_next, flag_noack_next, done_pulse,
                        (phase_next != PH_IDLE), pin_en_next, pin_data_next,
                        pin_sck_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_count     <= 3'd0;
      delay_count   <= 16'd0;
      wait_count    <= 24'd0;
      shift_byte    <= 8'd0;
      command_latch <= 5'd0;
      value_reg     <= 16'd0;
      crc_running   <= 8'd0;
      crc_read      <= 8'd0;
      pin_sck       <= 1'b1;
      pin_data      <= 1'b0;
      pin_en        <= 1'b1;
      byte_index    <= 2'd0;
      flag_noack    <= 1'b0;
      flag_timeout  <= 1'b0;
      flag_crcgot   <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      bit_count     <= bit_count_next;
      delay_count   <= delay_count_next;
      wait_count    <= wait_count_next;
      shift_byte    <= shift_byte_next;
      command_latch <= command_latch_next;
      value_reg     <= value_reg_next;
      crc_running   <= crc_running_next;
      crc_read      <= crc_read_next;
      pin_sck       <= pin_sck_next;
      pin_data      <= pin_data_next;
      pin_en        <= pin_en_next;
      byte_index    <= byte_index_next;
      flag_noack    <= flag_noack_next;
      flag_timeout  <= flag_timeout_next;
      flag_crcgot   <= flag_crcgot_next;
    end
  end

  // output register plus skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_axis_tready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_axis_tready || !out_valid) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (accept) begin
        out_word <= result_word;
      end
    end else if (accept) begin
      skid_word <= result_word;
    end
  end

endmodule
